// ===== hw/rtl/ple_pkg.sv =====
// Package for the positional list engine: sizes, request and status codes,
// and the control struct broadcast from the top level to the row of cells.
// No dependencies.
package ple_pkg;

  localparam int DEPTH = 64;
  localparam int PW    = 8;
  localparam int DW    = 32;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int XW    = ((CW > PW) ? CW : PW) + 1;
  localparam int OCW   = 7;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IW-1:0]     idx;
    logic [DW-1:0]     value;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/ple_cell.sv =====
// One list entry of the positional list engine. Takes the left neighbor on
// insert, the right neighbor on remove, and taps its entry for reads.
// Depends on ple_pkg.
module ple_cell (
  input  logic                      clk,
  input  ple_pkg::cell_ctl_t        ctl,
  input  logic [ple_pkg::IW-1:0]    my_index,
  input  logic [ple_pkg::DW-1:0]    left_d,
  input  logic [ple_pkg::DW-1:0]    right_d,
  output logic [ple_pkg::DW-1:0]    data_q,
  output logic [ple_pkg::DW-1:0]    rd_tap
);

  logic [ple_pkg::DW-1:0] data_r;
  logic [ple_pkg::DW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      ple_pkg::CELL_INSERT: begin
        if (my_index > ctl.idx) begin
          data_nxt = left_d;
        end else if (my_index == ctl.idx) begin
          data_nxt = ctl.value;
        end
      end
      ple_pkg::CELL_REMOVE: begin
        if (my_index >= ctl.idx) begin
          data_nxt = right_d;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  assign rd_tap = (my_index == ctl.idx) ? data_r : '0;

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// Positional list engine: ordered list of signed 32-bit entries in a row of
// cells that shift together. The result is registered in the cycle after the
// item is accepted. Throughput: one item per cycle while results are taken.
// Reset: synchronous active-low; clears the count and the output valid.
// Entries hold no reset and are only read below the count. Depends on ple_pkg.
module positional_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[7:0], value[39:8]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value[31:0], status[33:32], entry_count[40:34]
);

  logic                     out_tvalid_r;
  logic                     out_tvalid_nxt;
  logic [47:0]              out_tdata_r;
  logic [ple_pkg::CW-1:0]   count_r;
  logic [ple_pkg::CW-1:0]   count_nxt;

  logic                     in_acc;
  logic [1:0]               kind;
  logic [ple_pkg::PW-1:0]   pos;
  logic [ple_pkg::DW-1:0]   val;
  logic [ple_pkg::XW-1:0]   pos_x;
  logic [ple_pkg::XW-1:0]   cnt_x;
  logic [ple_pkg::IW-1:0]   ins_idx;
  logic [ple_pkg::IW-1:0]   ex_idx;
  logic                     full;
  logic                     empty;
  ple_pkg::cell_ctl_t       ctl;
  logic [ple_pkg::DW-1:0]   rd_data;
  logic [ple_pkg::DW-1:0]   res_value;
  logic [1:0]               res_status;

  logic [ple_pkg::DW-1:0]   cell_q   [ple_pkg::DEPTH];
  logic [ple_pkg::DW-1:0]   cell_tap [ple_pkg::DEPTH];

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign kind      = in_tuser;
  assign pos       = in_tdata[7:0];
  assign val       = in_tdata[39:8];
  assign pos_x     = ple_pkg::XW'(pos);
  assign cnt_x     = ple_pkg::XW'(count_r);
  assign full      = (count_r == ple_pkg::CW'(ple_pkg::DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    if (pos_x <= ple_pkg::XW'(1)) begin
      ins_idx = '0;
    end else if (pos_x >= cnt_x + ple_pkg::XW'(1)) begin
      ins_idx = ple_pkg::IW'(count_r);
    end else begin
      ins_idx = ple_pkg::IW'(pos_x - ple_pkg::XW'(1));
    end
    if (pos_x <= ple_pkg::XW'(1)) begin
      ex_idx = '0;
    end else if (pos_x >= cnt_x) begin
      ex_idx = ple_pkg::IW'(cnt_x - ple_pkg::XW'(1));
    end else begin
      ex_idx = ple_pkg::IW'(pos_x - ple_pkg::XW'(1));
    end
  end

  always_comb begin
    ctl.op    = ple_pkg::CELL_HOLD;
    ctl.idx   = ex_idx;
    ctl.value = val;
    count_nxt = count_r;
    res_value = '0;
    res_status = ple_pkg::ST_OK;
    case (kind)
      ple_pkg::KIND_INSERT: begin
        ctl.idx = ins_idx;
        if (full) begin
          res_status = ple_pkg::ST_FULL;
        end else begin
          ctl.op    = in_acc ? ple_pkg::CELL_INSERT : ple_pkg::CELL_HOLD;
          count_nxt = count_r + ple_pkg::CW'(1);
        end
      end
      ple_pkg::KIND_REMOVE: begin
        if (empty) begin
          res_status = ple_pkg::ST_EMPTY;
        end else begin
          ctl.op    = in_acc ? ple_pkg::CELL_REMOVE : ple_pkg::CELL_HOLD;
          count_nxt = count_r - ple_pkg::CW'(1);
        end
      end
      ple_pkg::KIND_READ: begin
        if (empty) begin
          res_status = ple_pkg::ST_EMPTY;
          res_value  = '1;
        end else begin
          res_value = rd_data;
        end
      end
      default: count_nxt = '0;
    endcase
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < ple_pkg::DEPTH; i++) begin
      rd_data = rd_data | cell_tap[i];
    end
  end

  for (genvar g = 0; g < ple_pkg::DEPTH; g++) begin : g_cell
    logic [ple_pkg::DW-1:0] left_d;
    logic [ple_pkg::DW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_q[g-1];
    end
    if (g == ple_pkg::DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_q[g+1];
    end
    ple_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .my_index (ple_pkg::IW'(g)),
      .left_d   (left_d),
      .right_d  (right_d),
      .data_q   (cell_q[g]),
      .rd_tap   (cell_tap[g])
    );
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (in_acc) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      count_r      <= '0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (in_acc) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= {7'd0, ple_pkg::OCW'(count_nxt), res_status, res_value};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== hw/rtl/ple_checker.sv =====
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine.
module ple_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("no result after accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == ple_pkg::KIND_CLEAR) |=>
    (out_tdata[40:34] == 7'd0 && out_tdata[33:32] == ple_pkg::ST_OK))
    else $error("clear did not empty the list");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33:32] == ple_pkg::ST_FULL) |->
    (out_tdata[40:34] == 7'(ple_pkg::DEPTH % 128)))
    else $error("full status with wrong count");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
